FILE: design/rth_pkg.sv
package rth_pkg;

    localparam int PIX_W         = 8;
    localparam int HUE_W         = 15;
    localparam int DIV_W         = 9;
    localparam int SECT_W        = 11;
    localparam int HUE_NUM_W     = 23;
    localparam int HUE_SCALE     = 3840;
    localparam int HUE_FULL      = 23040;
    localparam int LIGHT_DEN     = 510;
    localparam int HALF_SUM      = 255;
    localparam int N_LANE        = 2;
    localparam int LANE_HUE      = 0;
    localparam int LANE_SAT      = 1;
    localparam int FRAC_BITS_DEF = 16;
    localparam int STEP_BITS_DEF = 4;

    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } sector_t;

endpackage

FILE: design/rth_front.sv
module rth_front
    import rth_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int QP        = 20
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [PIX_W-1:0]                 red,
    input  logic [PIX_W-1:0]                 green,
    input  logic [PIX_W-1:0]                 blue,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [N_LANE-1:0][DIV_W-1:0]     out_rem,
    output logic [N_LANE-1:0][DIV_W-1:0]     out_den,
    output logic [N_LANE-1:0][QP-1:0]        out_work,
    output logic [FRAC_BITS:0]               out_lit,
    output logic                             out_grey
);

    localparam int NW = (HUE_NUM_W > FRAC_BITS + DIV_W) ? HUE_NUM_W : FRAC_BITS + DIV_W;

    // stage a: max, min and sector
    logic             a_valid_reg;
    logic             a_ready;
    logic [PIX_W-1:0] a_red_reg, a_green_reg, a_blue_reg, a_mx_reg, a_mn_reg;
    logic [PIX_W-1:0] a_mx_next, a_mn_next;
    sector_t          a_sec_reg, a_sec_next;

    // stage b: difference, sum, sector numerator, saturation divisor
    logic              b_valid_reg;
    logic              b_ready;
    logic [PIX_W-1:0]  b_d_reg, b_d_next;
    logic [DIV_W-1:0]  b_sm_reg, b_sm_next;
    logic [SECT_W-1:0] b_n_reg, b_n_next;
    logic [DIV_W-1:0]  b_den_reg, b_den_next;
    logic              b_grey_reg, b_grey_next;

    // stage c: divider operands and lightness
    logic                         c_valid_reg;
    logic                         c_ready;
    logic [N_LANE-1:0][NW-1:0]    num;
    logic [N_LANE-1:0][DIV_W-1:0] c_rem_reg, c_rem_next, c_den_reg, c_den_next;
    logic [N_LANE-1:0][QP-1:0]    c_work_reg, c_work_next;
    logic [FRAC_BITS:0]           c_lit_reg, c_lit_next;
    logic                         c_grey_reg;
    logic [1:0]                   lit_whole;
    logic [PIX_W-1:0]             lit_part;
    logic [FRAC_BITS-1:0]         lit_pat;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        a_mx_next = red;
        if (green > a_mx_next) a_mx_next = green;
        if (blue > a_mx_next) a_mx_next = blue;
        a_mn_next = red;
        if (green < a_mn_next) a_mn_next = green;
        if (blue < a_mn_next) a_mn_next = blue;
        if (red == a_mx_next) begin
            a_sec_next = SEC_RED;
        end else if (green == a_mx_next) begin
            a_sec_next = SEC_GREEN;
        end else begin
            a_sec_next = SEC_BLUE;
        end
    end

    always_comb begin
        logic [SECT_W-1:0] d_w, r_w, g_w, b_w;
        b_d_next    = a_mx_reg - a_mn_reg;
        b_sm_next   = DIV_W'(a_mx_reg) + DIV_W'(a_mn_reg);
        b_grey_next = (b_d_next == '0);
        d_w = SECT_W'(b_d_next);
        r_w = SECT_W'(a_red_reg);
        g_w = SECT_W'(a_green_reg);
        b_w = SECT_W'(a_blue_reg);
        case (a_sec_reg)
            SEC_RED: begin
                if (a_green_reg >= a_blue_reg) begin
                    b_n_next = g_w - b_w;
                end else begin
                    b_n_next = (d_w << 2) + (d_w << 1) - (b_w - g_w);
                end
            end
            SEC_GREEN: b_n_next = (d_w << 1) + b_w - r_w;
            SEC_BLUE:  b_n_next = (d_w << 2) + r_w - g_w;
            default:   b_n_next = '0;
        endcase
        if (b_sm_next <= DIV_W'(HALF_SUM)) begin
            b_den_next = b_sm_next;
        end else begin
            b_den_next = DIV_W'(LIGHT_DEN) - b_sm_next;
        end
    end

    always_comb begin
        logic [NW+QP-1:0] ext;
        num[LANE_HUE] = NW'(b_n_reg) * NW'(HUE_SCALE);
        num[LANE_SAT] = NW'(b_d_reg) << FRAC_BITS;
        c_den_next[LANE_HUE] = DIV_W'(b_d_reg);
        c_den_next[LANE_SAT] = b_den_reg;
        for (int l = 0; l < N_LANE; l++) begin
            ext            = (NW+QP)'(num[l]);
            c_rem_next[l]  = DIV_W'(ext >> QP);
            c_work_next[l] = ext[QP-1:0];
        end
    end

    // lightness: whole 255ths of the sum, the rest over 255 is its own bits repeated
    always_comb begin
        if (b_sm_reg >= DIV_W'(LIGHT_DEN)) begin
            lit_whole = 2'd2;
            lit_part  = '0;
        end else if (b_sm_reg >= DIV_W'(HALF_SUM)) begin
            lit_whole = 2'd1;
            lit_part  = PIX_W'(b_sm_reg - DIV_W'(HALF_SUM));
        end else begin
            lit_whole = 2'd0;
            lit_part  = PIX_W'(b_sm_reg);
        end
        for (int k = 0; k < FRAC_BITS; k++) begin
            lit_pat[k] = lit_part[PIX_W-1-((FRAC_BITS-1-k) % PIX_W)];
        end
        c_lit_next = {lit_whole, lit_pat[FRAC_BITS-1:1]} + (FRAC_BITS+1)'(lit_pat[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg <= in_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (c_ready) c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_red_reg   <= red;
            a_green_reg <= green;
            a_blue_reg  <= blue;
            a_mx_reg    <= a_mx_next;
            a_mn_reg    <= a_mn_next;
            a_sec_reg   <= a_sec_next;
        end
        if (a_valid_reg && b_ready) begin
            b_d_reg    <= b_d_next;
            b_sm_reg   <= b_sm_next;
            b_n_reg    <= b_n_next;
            b_den_reg  <= b_den_next;
            b_grey_reg <= b_grey_next;
        end
        if (b_valid_reg && c_ready) begin
            c_rem_reg  <= c_rem_next;
            c_den_reg  <= c_den_next;
            c_work_reg <= c_work_next;
            c_lit_reg  <= c_lit_next;
            c_grey_reg <= b_grey_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_rem   = c_rem_reg;
    assign out_den   = c_den_reg;
    assign out_work  = c_work_reg;
    assign out_lit   = c_lit_reg;
    assign out_grey  = c_grey_reg;

endmodule

FILE: design/rth_div_step.sv
module rth_div_step
    import rth_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int QP        = 20,
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [N_LANE-1:0][DIV_W-1:0] in_rem,
    input  logic [N_LANE-1:0][DIV_W-1:0] in_den,
    input  logic [N_LANE-1:0][QP-1:0]    in_work,
    input  logic [FRAC_BITS:0]           in_lit,
    input  logic                         in_grey,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [N_LANE-1:0][DIV_W-1:0] out_rem,
    output logic [N_LANE-1:0][DIV_W-1:0] out_den,
    output logic [N_LANE-1:0][QP-1:0]    out_work,
    output logic [FRAC_BITS:0]           out_lit,
    output logic                         out_grey
);

    logic                         valid_reg;
    logic [N_LANE-1:0][DIV_W-1:0] rem_reg, rem_next, den_reg;
    logic [N_LANE-1:0][QP-1:0]    work_reg, work_next;
    logic [FRAC_BITS:0]           lit_reg;
    logic                         grey_reg;

    assign in_ready = !valid_reg || out_ready;

    // restoring division, quotient bits shift in at the bottom of the work word
    always_comb begin
        logic [DIV_W:0]   trial;
        logic [DIV_W-1:0] rem;
        logic [QP-1:0]    work;
        logic             qbit;
        for (int l = 0; l < N_LANE; l++) begin
            rem  = in_rem[l];
            work = in_work[l];
            for (int s = 0; s < STEP_BITS; s++) begin
                trial = {rem, work[QP-1]};
                qbit  = (trial >= {1'b0, in_den[l]});
                if (qbit) begin
                    rem = DIV_W'(trial - {1'b0, in_den[l]});
                end else begin
                    rem = trial[DIV_W-1:0];
                end
                work = {work[QP-2:0], qbit};
            end
            rem_next[l]  = rem;
            work_next[l] = work;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
            den_reg  <= in_den;
            lit_reg  <= in_lit;
            grey_reg <= in_grey;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_work  = work_reg;
    assign out_lit   = lit_reg;
    assign out_grey  = grey_reg;

endmodule

FILE: design/rth_round.sv
module rth_round
    import rth_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int QP        = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [N_LANE-1:0][DIV_W-1:0] in_rem,
    input  logic [N_LANE-1:0][DIV_W-1:0] in_den,
    input  logic [N_LANE-1:0][QP-1:0]    in_work,
    input  logic [FRAC_BITS:0]           in_lit,
    input  logic                         in_grey,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [HUE_W-1:0]             hue,
    output logic [FRAC_BITS:0]           saturation,
    output logic [FRAC_BITS:0]           lightness
);

    localparam int SL_W = FRAC_BITS + 1;

    logic              valid_reg;
    logic [HUE_W-1:0]  hue_reg, hue_next;
    logic [SL_W-1:0]   sat_reg, sat_next, lit_reg, lit_next;
    logic [N_LANE-1:0] up;
    logic [HUE_W:0]    hue_sum;

    assign in_ready = !valid_reg || out_ready;

    // round half up from the final remainder
    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            up[l] = ({in_rem[l], 1'b0} >= {1'b0, in_den[l]});
        end
        hue_sum = (HUE_W+1)'(in_work[LANE_HUE][HUE_W-1:0]) + (HUE_W+1)'(up[LANE_HUE]);
        if (hue_sum >= (HUE_W+1)'(HUE_FULL)) begin
            hue_sum = hue_sum - (HUE_W+1)'(HUE_FULL);
        end
        hue_next = in_grey ? '0 : hue_sum[HUE_W-1:0];
        sat_next = in_grey ? '0 : in_work[LANE_SAT][SL_W-1:0] + SL_W'(up[LANE_SAT]);
        lit_next = in_lit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            lit_reg <= lit_next;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = lit_reg;

endmodule

FILE: design/rgb_to_hsl.sv
// rgb_to_hsl: converts one 8-bit rgb pixel per transfer into hue (degrees, 6 fraction bits),
// saturation and lightness (FRAC_BITS fraction bits, 1 << FRAC_BITS is 1.0), all rounded to
// nearest. The pipeline takes one pixel every clock unless backpressure stalls it. It is
// three front stages (max/min, sector numerator, divider operands and lightness), the divider
// stages that each retire STEP_BITS quotient bits for the hue and saturation quotients, and
// the rounding stage that is the output register. Backpressure stalls only the stages that are
// full, so bubbles are squeezed out while m_tready is low.
module rgb_to_hsl
    import rth_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int STEP_BITS = STEP_BITS_DEF,
    localparam int SL_W  = FRAC_BITS + 1,
    localparam int OUT_W = ((HUE_W + 2 * SL_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // red, green, blue
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // hue, saturation, lightness, zero pad
);

    localparam int QW   = (HUE_W > SL_W) ? HUE_W : SL_W;
    localparam int NSTG = (QW + STEP_BITS - 1) / STEP_BITS;
    localparam int QP   = NSTG * STEP_BITS;

    logic [NSTG:0]                            st_valid, st_ready, st_grey;
    logic [NSTG:0][N_LANE-1:0][DIV_W-1:0]     st_rem, st_den;
    logic [NSTG:0][N_LANE-1:0][QP-1:0]        st_work;
    logic [NSTG:0][SL_W-1:0]                  st_lit;
    logic [HUE_W-1:0]                         hue;
    logic [SL_W-1:0]                          saturation, lightness;

    rth_front #(
        .FRAC_BITS (FRAC_BITS),
        .QP        (QP)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_rem   (st_rem[0]),
        .out_den   (st_den[0]),
        .out_work  (st_work[0]),
        .out_lit   (st_lit[0]),
        .out_grey  (st_grey[0])
    );

    for (genvar i = 0; i < NSTG; i++) begin : g_div
        rth_div_step #(
            .FRAC_BITS (FRAC_BITS),
            .QP        (QP),
            .STEP_BITS (STEP_BITS)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_rem    (st_rem[i]),
            .in_den    (st_den[i]),
            .in_work   (st_work[i]),
            .in_lit    (st_lit[i]),
            .in_grey   (st_grey[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_rem   (st_rem[i+1]),
            .out_den   (st_den[i+1]),
            .out_work  (st_work[i+1]),
            .out_lit   (st_lit[i+1]),
            .out_grey  (st_grey[i+1])
        );
    end

    rth_round #(
        .FRAC_BITS (FRAC_BITS),
        .QP        (QP)
    ) u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (st_valid[NSTG]),
        .in_ready   (st_ready[NSTG]),
        .in_rem     (st_rem[NSTG]),
        .in_den     (st_den[NSTG]),
        .in_work    (st_work[NSTG]),
        .in_lit     (st_lit[NSTG]),
        .in_grey    (st_grey[NSTG]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    assign m_tdata = OUT_W'({lightness, saturation, hue});

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (hue < HUE_W'(HUE_FULL)))
        else $error("hue not wrapped below full circle");

    a_sl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (saturation <= (SL_W'(1) << FRAC_BITS))
                     && (lightness <= (SL_W'(1) << FRAC_BITS)))
        else $error("saturation or lightness above one");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

endmodule
